// ===== rtl/boel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package boel_pkg;

  // Field widths fixed by the interface.
  localparam int IdW    = 64;
  localparam int PayW   = 64;
  localparam int PosW   = 6;
  localparam int CountW = 7;
  localparam int OpW    = 3;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR    = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_FIND     = 3'd3,
    OP_READ     = 3'd4,
    OP_TRUNCATE = 3'd5
  } boel_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } boel_state_t;

  // Register index of the capacity register.
  localparam logic REG_MAX_EDGES = 1'b0;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PayW-1:0] payload;
  } boel_entry_t;

  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] pos;
    boel_entry_t     entry;
  } boel_res_t;

  typedef struct packed {
    logic take_new;
    logic take_prev;
    logic take_next;
    logic capture;
    logic read_hit;
    logic find_en;
    logic merge;
  } boel_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/boel_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module boel_cell (
  input  logic                          clk,
  input  boel_pkg::boel_cell_ctl_t      ctl,
  input  boel_pkg::boel_entry_t         new_entry,
  input  boel_pkg::boel_entry_t         prev_entry,
  input  boel_pkg::boel_entry_t         next_entry,
  input  logic [boel_pkg::IdW-1:0]      key,
  input  logic [boel_pkg::PosW-1:0]     own_pos,
  input  boel_pkg::boel_res_t           next_res,
  output boel_pkg::boel_entry_t         entry,
  output boel_pkg::boel_res_t           res
);

  logic hit;

  assign hit = ctl.read_hit | (ctl.find_en && (entry.id == key));

  // Stored edge: shifts in from either neighbor or loads the inserted edge.
  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      entry <= new_entry;
    end else if (ctl.take_prev) begin
      entry <= prev_entry;
    end else if (ctl.take_next) begin
      entry <= next_entry;
    end
  end

  // Lookup result: captured locally, then passed down toward cell zero
  // unless this cell already holds a hit.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      res <= '{hit: hit, pos: own_pos, entry: entry};
    end else if (ctl.merge && !res.hit) begin
      res <= next_res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_ordered_edge_list.sv =====
// Clear, insert, delete, truncate, rejected words, a read at position zero and a find on
// a list of at most one edge load the result word without a merge; any other lookup
// first passes its result down the cells toward cell zero, one cell per cycle. Loading
// waits while an earlier result word is still held back by the receiver. Only one word is
// in flight: the next word is taken only after the result word of the last is loaded.
// Synchronous active-high reset empties the list and sets the capacity register to 64.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_edge_list #(
  parameter int MAX_EDGES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [boel_pkg::OpW-1:0]         op,
  input  logic [boel_pkg::PosW-1:0]        position,
  input  logic [boel_pkg::IdW-1:0]         edge_id,
  input  logic [boel_pkg::PayW-1:0]        payload,
  input  logic [boel_pkg::CountW-1:0]      new_count,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic [boel_pkg::PosW-1:0]        found_position,
  output logic [boel_pkg::IdW-1:0]         edge_id_out,
  output logic [boel_pkg::PayW-1:0]        payload_out,
  output logic [boel_pkg::CountW-1:0]      count,
  output logic                             error,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [boel_pkg::AddrW-1:0]       paddr,
  input  logic [boel_pkg::DataW-1:0]       pwdata,
  output logic [boel_pkg::DataW-1:0]       prdata,
  output logic                             pready
);

  // Compare width: wide enough for every cell index and every 7-bit count, plus one.
  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = ((IW > boel_pkg::CountW) ? IW : boel_pkg::CountW) + 1;
  localparam logic [CW-1:0] MaxC = CW'(MAX_EDGES);

  // Effective capacity: the register clamped to 1..MAX_EDGES. It never exceeds 127.
  function automatic logic [CW-1:0] cap_of(input logic [boel_pkg::CountW-1:0] m);
    logic [CW-1:0] mw;
    mw = CW'(m);
    if (m == '0) begin
      cap_of = CW'(1);
    end else if (mw > MaxC) begin
      cap_of = MaxC;
    end else begin
      cap_of = mw;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  boel_pkg::boel_state_t state, state_next;
  logic [boel_pkg::CountW-1:0] max_edges;
  logic [boel_pkg::CountW-1:0] edge_count, edge_count_next;
  logic [boel_pkg::CountW-1:0] steps, steps_next;
  logic                        res_look, res_read, res_error;
  logic                        res_error_next;

  logic accept, cfg_write, merge_en, out_load;
  logic [CW-1:0] pos_w, cnt_w, cap_w, keep_w, ins_n_w;
  logic ins_ok, del_ok, read_ok, trunc_ok, is_find, is_read, lookup;
  logic [boel_pkg::CountW-1:0] steps_init, cfg_cap;

  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == boel_pkg::REG_MAX_EDGES);

  assign pos_w   = CW'(position);
  assign cnt_w   = CW'(edge_count);
  assign keep_w  = CW'(new_count);
  assign cap_w   = cap_of(max_edges);
  assign ins_n_w = (cnt_w < cap_w) ? cnt_w + CW'(1) : cnt_w;
  assign cfg_cap = boel_pkg::CountW'(cap_of(pwdata[boel_pkg::CountW-1:0]));

  assign ins_ok   = (pos_w < cap_w) && (pos_w <= cnt_w);
  assign del_ok   = pos_w < cnt_w;
  assign read_ok  = pos_w < cnt_w;
  assign trunc_ok = keep_w <= cnt_w;
  assign is_find  = op == boel_pkg::OP_FIND;
  assign is_read  = (op == boel_pkg::OP_READ) && read_ok;
  assign lookup   = is_find || is_read;

  // Merge steps: a find must sweep the live cells, a read only reach the target cell.
  assign steps_init = is_find ? ((edge_count == '0) ? '0 : edge_count - 7'd1)
                              : 7'(position);

  // Count and error decided on the accepting edge.
  always_comb begin
    edge_count_next = edge_count;
    res_error_next  = 1'b0;
    case (op)
      boel_pkg::OP_CLEAR: begin
        edge_count_next = '0;
      end
      boel_pkg::OP_INSERT: begin
        if (ins_ok) begin
          edge_count_next = boel_pkg::CountW'(ins_n_w);
        end else begin
          res_error_next = 1'b1;
        end
      end
      boel_pkg::OP_DELETE: begin
        if (del_ok) begin
          edge_count_next = edge_count - 7'd1;
        end else begin
          res_error_next = 1'b1;
        end
      end
      boel_pkg::OP_FIND: begin
        res_error_next = 1'b0;
      end
      boel_pkg::OP_READ: begin
        res_error_next = !read_ok;
      end
      boel_pkg::OP_TRUNCATE: begin
        if (trunc_ok) begin
          edge_count_next = new_count;
        end else begin
          res_error_next = 1'b1;
        end
      end
      default: begin
        res_error_next = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    steps_next = steps;
    case (state)
      boel_pkg::ST_IDLE: begin
        if (accept) begin
          steps_next = steps_init;
          state_next = (lookup && (steps_init != '0)) ? boel_pkg::ST_MERGE
                                                      : boel_pkg::ST_EMIT;
        end
      end
      boel_pkg::ST_MERGE: begin
        steps_next = steps - 7'd1;
        if (steps == 7'd1) begin
          state_next = boel_pkg::ST_EMIT;
        end
      end
      boel_pkg::ST_EMIT: begin
        if (out_load) begin
          state_next = boel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = boel_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    merge_en = 1'b0;
    out_load = 1'b0;
    case (state)
      boel_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      boel_pkg::ST_MERGE: begin
        merge_en = 1'b1;
      end
      boel_pkg::ST_EMIT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= boel_pkg::ST_IDLE;
      steps      <= '0;
      edge_count <= '0;
      max_edges  <= 7'd64;
      res_look   <= 1'b0;
      res_read   <= 1'b0;
      res_error  <= 1'b0;
    end else begin
      state <= state_next;
      steps <= steps_next;
      if (cfg_write) begin
        // Lowering the capacity cuts the list down to it.
        max_edges <= pwdata[boel_pkg::CountW-1:0];
        if (edge_count > cfg_cap) begin
          edge_count <= cfg_cap;
        end
      end else if (accept) begin
        edge_count <= edge_count_next;
      end
      if (accept) begin
        res_look  <= lookup;
        res_read  <= is_read;
        res_error <= res_error_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Chain of cells
  // ---------------------------------------------------------------------------
  boel_pkg::boel_entry_t    entries [MAX_EDGES];
  boel_pkg::boel_res_t      results [MAX_EDGES];
  boel_pkg::boel_cell_ctl_t ctl     [MAX_EDGES];
  boel_pkg::boel_entry_t    new_entry;

  logic ins_go, del_go, capture;

  assign new_entry = '{id: edge_id, payload: payload};
  assign ins_go    = accept && (op == boel_pkg::OP_INSERT) && ins_ok;
  assign del_go    = accept && (op == boel_pkg::OP_DELETE) && del_ok;
  assign capture   = accept && lookup;

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    boel_pkg::boel_entry_t prev_e, next_e;
    boel_pkg::boel_res_t   next_r;

    // Insert moves cells above the position up; delete moves cells from it down.
    assign ctl[i].take_new  = ins_go && (Idx == pos_w);
    assign ctl[i].take_prev = ins_go && (Idx > pos_w) && (Idx < ins_n_w);
    assign ctl[i].take_next = del_go && (Idx >= pos_w) && ((Idx + CW'(1)) < cnt_w);
    assign ctl[i].capture   = capture;
    assign ctl[i].read_hit  = is_read && (Idx == pos_w);
    assign ctl[i].find_en   = is_find && (Idx < cnt_w);
    assign ctl[i].merge     = merge_en;

    if (i == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid
      assign prev_e = entries[i-1];
    end

    if (i == MAX_EDGES - 1) begin : g_last
      assign next_e = '0;
      assign next_r = '0;
    end else begin : g_inner
      assign next_e = entries[i+1];
      assign next_r = results[i+1];
    end

    boel_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .key        (edge_id),
      .own_pos    (boel_pkg::PosW'(i)),
      .next_res   (next_r),
      .entry      (entries[i]),
      .res        (results[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic hit0;
  assign hit0 = res_look && results[0].hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found          <= hit0;
      found_position <= hit0 ? results[0].pos : '0;
      edge_id_out    <= (hit0 && res_read) ? results[0].entry.id : '0;
      payload_out    <= (hit0 && res_read) ? results[0].entry.payload : '0;
      count          <= edge_count;
      error          <= res_error;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration read
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == boel_pkg::REG_MAX_EDGES)
                ? boel_pkg::DataW'(max_edges) : '0;

endmodule

`default_nettype wire

// ===== test/bounded_ordered_edge_list_test.sv =====
`timescale 1ns / 1ps

// Self-checking test of the bounded ordered edge list.
// A stimulus process sends request words through the valid/ready input channel. A shadow copy
// of the edge list, kept inside this module, works out the result word for each accepted
// request. A checker process compares every accepted result word with the oldest pending
// prediction, one field at a time. The capacity register is written over the APB-style port
// only while the block is idle.
module bounded_ordered_edge_list_test;

  localparam int MaxEdges = 64;
  // A read at the last position passes its result through every cell, and the sender and
  // receiver add short gaps and stalls on top of that. This limit is many times the longest
  // quiet spell that a correct run can show.
  localparam int HangLimit = 2000;
  localparam int DrainCycles = 70;

  // The two op codes that the block must reject.
  localparam logic [boel_pkg::OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [boel_pkg::OpW-1:0] OP_SPARE_7 = 3'd7;
  localparam logic [boel_pkg::AddrW-1:0] MAX_EDGES_ADDR =
      boel_pkg::AddrW'(4 * boel_pkg::REG_MAX_EDGES);

  typedef struct packed {
    logic                        hit;
    logic [boel_pkg::PosW-1:0]   hit_pos;
    logic [boel_pkg::IdW-1:0]    id;
    logic [boel_pkg::PayW-1:0]   pay;
    logic [boel_pkg::CountW-1:0] count;
    logic                        err;
  } edge_answer_t;

  // These are the stall patterns of the result receiver.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_TOGGLE
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [boel_pkg::OpW-1:0]    op = '0;
  logic [boel_pkg::PosW-1:0]   position = '0;
  logic [boel_pkg::IdW-1:0]    edge_id = '0;
  logic [boel_pkg::PayW-1:0]   payload = '0;
  logic [boel_pkg::CountW-1:0] new_count = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        found;
  logic [boel_pkg::PosW-1:0]   found_position;
  logic [boel_pkg::IdW-1:0]    edge_id_out;
  logic [boel_pkg::PayW-1:0]   payload_out;
  logic [boel_pkg::CountW-1:0] count;
  logic                        error;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [boel_pkg::AddrW-1:0]  paddr = '0;
  logic [boel_pkg::DataW-1:0]  pwdata = '0;
  logic [boel_pkg::DataW-1:0]  prdata;
  logic                        pready;

  // The shadow edge list. Only entries below shadow_count are ever looked at, and each of
  // those has been written, so the entries need no reset.
  logic [boel_pkg::IdW-1:0]    shadow_ids [MaxEdges];
  logic [boel_pkg::PayW-1:0]   shadow_pays[MaxEdges];
  int unsigned       shadow_count = 0;
  int unsigned       shadow_max = 64;

  edge_answer_t      answers_due[$];
  int unsigned       error_total = 0;
  int unsigned       burst_left = 0;
  int unsigned       quiet_cycles = 0;

  always #6 clk = ~clk;

  bounded_ordered_edge_list #(.MAX_EDGES(MaxEdges)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .position       (position),
    .edge_id        (edge_id),
    .payload        (payload),
    .new_count      (new_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .found_position (found_position),
    .edge_id_out    (edge_id_out),
    .payload_out    (payload_out),
    .count          (count),
    .error          (error),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // The effective capacity is the register value clamped to 1..MaxEdges.
  function automatic int unsigned edge_capacity();
    if (shadow_max < 1) return 1;
    if (shadow_max > MaxEdges) return MaxEdges;
    return shadow_max;
  endfunction

  // Apply one request to the shadow list and return the result word that it must give.
  function automatic edge_answer_t update_edge_list(input logic [boel_pkg::OpW-1:0] op_v,
      input logic [boel_pkg::PosW-1:0] pos_v, input logic [boel_pkg::IdW-1:0] id_v,
      input logic [boel_pkg::PayW-1:0] pay_v, input logic [boel_pkg::CountW-1:0] keep_v);
    edge_answer_t ans;
    int cap;
    int n;
    int p;
    ans = '0;
    cap = edge_capacity();
    p = pos_v;
    case (op_v)
      boel_pkg::OP_CLEAR: shadow_count = 0;
      boel_pkg::OP_INSERT: begin
        if (p >= cap || p > shadow_count) begin
          ans.err = 1'b1;
        end else begin
          // When the list is full, the entry at the top falls off during the shift.
          n = (shadow_count < cap) ? shadow_count + 1 : shadow_count;
          for (int i = n - 1; i > p; i--) begin
            shadow_ids[i]  = shadow_ids[i - 1];
            shadow_pays[i] = shadow_pays[i - 1];
          end
          shadow_ids[p]  = id_v;
          shadow_pays[p] = pay_v;
          shadow_count   = n;
        end
      end
      boel_pkg::OP_DELETE: begin
        if (p >= shadow_count) begin
          ans.err = 1'b1;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_ids[i]  = shadow_ids[i + 1];
            shadow_pays[i] = shadow_pays[i + 1];
          end
          shadow_count--;
        end
      end
      boel_pkg::OP_FIND: begin
        // The first match wins, and a miss is not an error.
        for (int i = 0; i < shadow_count; i++) begin
          if (!ans.hit && shadow_ids[i] == id_v) begin
            ans.hit     = 1'b1;
            ans.hit_pos = boel_pkg::PosW'(i);
          end
        end
      end
      boel_pkg::OP_READ: begin
        if (p >= shadow_count) begin
          ans.err = 1'b1;
        end else begin
          ans.hit     = 1'b1;
          ans.hit_pos = pos_v;
          ans.id      = shadow_ids[p];
          ans.pay     = shadow_pays[p];
        end
      end
      boel_pkg::OP_TRUNCATE: begin
        if (keep_v > shadow_count) ans.err = 1'b1;
        else shadow_count = keep_v;
      end
      default: ans.err = 1'b1;
    endcase
    ans.count = boel_pkg::CountW'(shadow_count);
    return ans;
  endfunction

  // Send one request word. The sender works in bursts: when a burst runs out, valid may drop
  // for a random gap before the next burst starts. The task is always entered just after a
  // rising edge, and it returns on the edge at which the word is accepted.
  task automatic send_word(input logic [boel_pkg::OpW-1:0] op_v,
      input logic [boel_pkg::PosW-1:0] pos_v, input logic [boel_pkg::IdW-1:0] id_v,
      input logic [boel_pkg::PayW-1:0] pay_v, input logic [boel_pkg::CountW-1:0] keep_v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    op        <= op_v;
    position  <= pos_v;
    edge_id   <= id_v;
    payload   <= pay_v;
    new_count <= keep_v;
    do @(posedge clk); while (!in_ready);
    // The prediction is made in this process, so the next random choice sees the new state.
    answers_due.push_back(update_edge_list(op_v, pos_v, id_v, pay_v, keep_v));
  endtask

  // Stop sending, then wait until every result word has come back. A short pause follows,
  // so that the block is surely idle before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register with a setup phase and then an access phase. Lowering the capacity also
  // cuts the edge count down to the new capacity.
  task automatic write_max_edges(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_EDGES_ADDR;
    pwdata  <= boel_pkg::DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_max = value & 32'h7f;
    if (shadow_count > edge_capacity()) shadow_count = edge_capacity();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Operations on an empty list: all lookups miss or are rejected.
  task automatic test_empty_list();
    write_max_edges(64);
    send_word(boel_pkg::OP_CLEAR, '0, '0, '0, '0);
    send_word(boel_pkg::OP_READ, '0, '0, '0, '0);
    send_word(boel_pkg::OP_DELETE, '0, '1, '1, '1);
    send_word(boel_pkg::OP_FIND, '1, '1, '0, '0);
    send_word(boel_pkg::OP_TRUNCATE, '0, '0, '0, 7'd1);
    send_word(boel_pkg::OP_TRUNCATE, '0, '0, '0, 7'd0);
  endtask

  // Shifting on insert and delete, first-match find, reads, and rejected requests.
  task automatic test_insert_shift();
    send_word(boel_pkg::OP_INSERT, 6'd1, 64'h1, 64'h2, '0);
    send_word(boel_pkg::OP_INSERT, 6'd0, '1, '1, '0);
    send_word(boel_pkg::OP_INSERT, 6'd0, '0, '0, '0);
    send_word(boel_pkg::OP_INSERT, 6'd2, 64'h5a5a_0000_ffff_1234, 64'h8000_0000_0000_0001,
              '0);
    send_word(boel_pkg::OP_FIND, '0, '1, '0, '0);
    send_word(boel_pkg::OP_INSERT, 6'd1, 64'h5a5a_0000_ffff_1234, 64'hdead_beef_0bad_f00d,
              '0);
    send_word(boel_pkg::OP_FIND, '0, 64'h5a5a_0000_ffff_1234, '0, '0);
    send_word(boel_pkg::OP_READ, 6'd3, '0, '0, '0);
    send_word(boel_pkg::OP_READ, 6'd63, '0, '0, '0);
    send_word(boel_pkg::OP_DELETE, 6'd1, '0, '0, '0);
    send_word(boel_pkg::OP_DELETE, 6'd63, '0, '0, '0);
    // Unknown op codes are rejected and leave the list as it is.
    send_word(OP_SPARE_6, '1, '1, '1, '1);
    send_word(OP_SPARE_7, '1, '1, '1, '1);
    send_word(boel_pkg::OP_TRUNCATE, '0, '0, '0, 7'd64);
    send_word(boel_pkg::OP_TRUNCATE, '0, '0, '0, 7'd2);
  endtask

  // Inserting into a full list drops the last edge. Lowering the capacity cuts the count.
  task automatic test_full_and_cut();
    settle();
    write_max_edges(3);
    send_word(boel_pkg::OP_INSERT, 6'd2, 64'h3, 64'h33, '0);
    send_word(boel_pkg::OP_INSERT, 6'd0, 64'h4, 64'h44, '0);
    send_word(boel_pkg::OP_INSERT, 6'd3, 64'h5, 64'h55, '0);
    send_word(boel_pkg::OP_READ, 6'd2, '0, '0, '0);
    settle();
    write_max_edges(1);
    send_word(boel_pkg::OP_READ, 6'd0, '0, '0, '0);
    send_word(boel_pkg::OP_INSERT, 6'd0, 64'h6, 64'h66, '0);
    send_word(boel_pkg::OP_INSERT, 6'd1, 64'h7, 64'h77, '0);
  endtask

  // Choose one random request. Most requests are well formed and use positions, ids and
  // counts that the current list makes meaningful. The rest may go out of range.
  task automatic send_random_word(input int unsigned insert_pct);
    int unsigned cap;
    int unsigned cnt;
    int unsigned pick;
    int unsigned top;
    logic [boel_pkg::OpW-1:0]    op_v;
    logic [boel_pkg::PosW-1:0]   pos_v;
    logic [boel_pkg::IdW-1:0]    id_v;
    logic [boel_pkg::PayW-1:0]   pay_v;
    logic [boel_pkg::CountW-1:0] keep_v;
    cap    = edge_capacity();
    cnt    = shadow_count;
    pay_v  = {$urandom, $urandom};
    pos_v  = boel_pkg::PosW'($urandom_range(0, 63));
    keep_v = boel_pkg::CountW'($urandom_range(0, 64));
    // A small pool of ids gives duplicates, so that find meets several matches.
    case ($urandom_range(0, 9))
      0: id_v = '1;
      1, 2, 3: id_v = boel_pkg::IdW'($urandom_range(0, 7));
      4, 5: id_v = (cnt != 0) ? shadow_ids[$urandom_range(0, cnt - 1)] : '0;
      default: id_v = {$urandom, $urandom};
    endcase
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      op_v = boel_pkg::OP_INSERT;
      top = (cnt < cap - 1) ? cnt : cap - 1;
      if ($urandom_range(0, 9) != 0) pos_v = boel_pkg::PosW'($urandom_range(0, top));
    end else if (pick < insert_pct + 18) begin
      op_v = boel_pkg::OP_READ;
      if (cnt != 0 && $urandom_range(0, 9) != 0)
        pos_v = boel_pkg::PosW'($urandom_range(0, cnt - 1));
    end else if (pick < insert_pct + 32) begin
      op_v = boel_pkg::OP_FIND;
    end else if (pick < insert_pct + 44) begin
      op_v = boel_pkg::OP_DELETE;
      if (cnt != 0 && $urandom_range(0, 9) != 0)
        pos_v = boel_pkg::PosW'($urandom_range(0, cnt - 1));
    end else if (pick < insert_pct + 52) begin
      op_v = boel_pkg::OP_TRUNCATE;
      // Mostly trim a few edges, so that the list can still grow toward full.
      if ($urandom_range(0, 4) != 0)
        keep_v = boel_pkg::CountW'((cnt > 3) ? $urandom_range(cnt - 3, cnt)
                                             : $urandom_range(0, cnt));
    end else if (pick < 98) begin
      op_v = ($urandom_range(0, 4) == 0) ? boel_pkg::OP_CLEAR : boel_pkg::OP_FIND;
    end else begin
      op_v = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
    end
    send_word(op_v, pos_v, id_v, pay_v, keep_v);
  endtask

  // Random traffic under several capacity settings, the extremes among them. Full-size
  // phases lean toward inserts, so that the list fills up to its capacity.
  task automatic test_random_traffic();
    int unsigned caps [10];
    caps = '{64, 1, 2, 5, 17, 64, 40, 63, 3, 64};
    foreach (caps[ph]) begin
      settle();
      write_max_edges(caps[ph]);
      for (int k = 0; k < 150; k++) send_random_word((caps[ph] == 64) ? 46 : 36);
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_total++;
    end
  endfunction

  // The result receiver switches between its stall patterns at random intervals.
  int unsigned rx_phase = 0;
  int unsigned rx_stall = 0;
  rx_mode_t    rx_mode = RX_STEADY;

  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_phase = $urandom_range(50, 300);
      rx_mode  = rx_mode_t'($urandom_range(0, 2));
    end
    rx_phase--;
    if (rx_stall != 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_RANDOM: begin
          if ($urandom_range(0, 3) == 0) begin
            rx_stall = $urandom_range(0, 9);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Every accepted result word is matched against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    edge_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("result word arrived with no prediction pending");
        error_total++;
      end else begin
        want = answers_due.pop_front();
        check_field("found", want.hit, found);
        check_field("found_position", want.hit_pos, found_position);
        check_field("edge_id_out", want.id, edge_id_out);
        check_field("payload_out", want.pay, payload_out);
        check_field("count", want.count, count);
        check_field("error", want.err, error);
      end
    end
  end

  // The watchdog counts cycles in which no input, output or register-write handshake completes.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == HangLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_insert_shift();
    test_full_and_cut();
    test_random_traffic();
    // Drain the pipeline, then give the block time to show any stray result word.
    settle();
    repeat (DrainCycles) @(posedge clk);
    if (error_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
